FILE: sv/clock_sorted_message_table_top_assert.svh
// assertion macros for the clock-sorted message table
`ifndef CLOCK_SORTED_MESSAGE_TABLE_TOP_ASSERT_SVH
`define CLOCK_SORTED_MESSAGE_TABLE_TOP_ASSERT_SVH

// condition implies consequence in the same cycle
`define CSMT_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// condition implies consequence in the next cycle
`define CSMT_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/csmt_pkg.sv
// package with sizes, codes and types of the clock-sorted message table
`default_nettype none

package csmt_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CLK_W       = 31;
  localparam int PAY_W       = 32;
  localparam int CAP_W       = 5;
  localparam int RCNT_W      = 5;
  localparam int IN_DATA_W   = 72;
  localparam int OUT_DATA_W  = 72;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_READ   = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_INSERTED = 2'd0,
    STAT_REJECTED = 2'd1,
    STAT_READ     = 2'd2,
    STAT_EMPTY    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_SCAN,
    S_INS_PUT,
    S_RD_DATA,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic [CLK_W-1:0] clock;
    logic [PAY_W-1:0] payload;
  } entry_t;

endpackage

`default_nettype wire

FILE: sv/clock_sorted_message_table_top.sv
// clock-sorted message table: bounded table of entries kept in descending clock order
//
//  channel   dir  handshake         contents
//  s_axis    in   tvalid / tready   tuser: command; tdata: entry_clock, payload,
//                                   read_count, read_all
//  m_axis    out  tvalid / tready   tuser: status; tdata: evicted, out_clock,
//                                   out_payload, stored_count; tlast: last
//  cfg       in   cfg_we            cfg_wdata: capacity
//
// an insert walks the sorted memory from the tail, one entry a cycle through the ports;
// a rejected insert, or one with nothing left to compare, goes straight to its result
// a read returns its entries one by one from the table; one that finds nothing gives a status
// results go through one output register, so a stalled m_axis holds a read walk and an insert's result
// input is taken only between items; a held result does not block the next transfer
// rst clears fill count and sets capacity to 16; the entry memory needs no clearing
`default_nettype none

module clock_sorted_message_table_top (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // [31:0] entry_clock, [63:32] payload, [68:64] read_count, [69] read_all
  input  wire logic [csmt_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // [0] command
  input  wire logic                             s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // [0] evicted, [31:1] out_clock, [63:32] out_payload, [68:64] stored_count
  output logic [csmt_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
  // [1:0] status
  output logic [1:0]                            m_axis_tuser,
  output logic                                  m_axis_tlast,
  input  wire logic                             cfg_we,
  input  wire logic [csmt_pkg::CAP_W-1:0]       cfg_wdata
);

  localparam int CNT_W = csmt_pkg::CNT_W;
  localparam int IDX_W = csmt_pkg::IDX_W;
  localparam int CLK_W = csmt_pkg::CLK_W;
  localparam int PAY_W = csmt_pkg::PAY_W;

  // input fields
  logic                          in_cmd;
  logic signed [31:0]            in_clock;
  logic [PAY_W-1:0]              in_payload;
  logic [csmt_pkg::RCNT_W-1:0]   in_read_count;
  logic                          in_read_all;

  assign in_cmd        = s_axis_tuser;
  assign in_clock      = s_axis_tdata[31:0];
  assign in_payload    = s_axis_tdata[63:32];
  assign in_read_count = s_axis_tdata[68:64];
  assign in_read_all   = s_axis_tdata[69];

  // state
  csmt_pkg::state_t   state, state_next;
  logic [CNT_W-1:0]   fill_count;
  logic [csmt_pkg::CAP_W-1:0] capacity;
  logic [CNT_W-1:0]   scan_idx;
  logic [IDX_W-1:0]   rd_idx;
  csmt_pkg::entry_t   work_entry;
  csmt_pkg::status_t  res_status;
  logic               res_evicted;

  // entry memory
  csmt_pkg::entry_t   mem [csmt_pkg::TABLE_DEPTH];
  csmt_pkg::entry_t   rdata;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  csmt_pkg::entry_t   mem_wdata;
  logic               mem_re;
  logic [IDX_W-1:0]   mem_raddr;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rdata <= mem[mem_raddr];
    end
  end

  // derived values
  logic               accept;
  logic               out_free;
  logic [CNT_W-1:0]   cap_eff;
  logic [CNT_W-1:0]   fill_adj;
  logic [CNT_W-1:0]   fill_adj_dec;
  logic               ins_evict;
  logic [CNT_W-1:0]   items;
  logic [CNT_W-1:0]   items_dec;
  logic [CNT_W-1:0]   scan_dec;
  logic [CNT_W-1:0]   scan_dec2;
  logic [IDX_W-1:0]   rd_dec;
  logic               shift_on;
  csmt_pkg::entry_t   new_entry;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_comb begin
    if (capacity == '0) begin
      cap_eff = CNT_W'(1);
    end else if (32'(capacity) > 32'(csmt_pkg::TABLE_DEPTH)) begin
      cap_eff = CNT_W'(csmt_pkg::TABLE_DEPTH);
    end else begin
      cap_eff = CNT_W'(capacity);
    end
  end

  // a full table (or one over a lowered capacity) drops down to one free slot
  assign ins_evict    = fill_count >= cap_eff;
  assign fill_adj     = ins_evict ? (cap_eff - CNT_W'(1)) : fill_count;
  assign fill_adj_dec = fill_adj - CNT_W'(1);

  always_comb begin
    if (in_read_all) begin
      items = fill_count;
    end else if (32'(in_read_count) < 32'(fill_count)) begin
      items = CNT_W'(in_read_count);
    end else begin
      items = fill_count;
    end
  end

  assign items_dec = items - CNT_W'(1);
  assign scan_dec  = scan_idx - CNT_W'(1);
  assign scan_dec2 = scan_idx - CNT_W'(2);
  assign rd_dec    = rd_idx - IDX_W'(1);
  assign shift_on  = rdata.clock < work_entry.clock;

  assign new_entry.clock   = in_clock[CLK_W-1:0];
  assign new_entry.payload = in_payload;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      csmt_pkg::S_IDLE: begin
        if (accept) begin
          if (in_cmd == csmt_pkg::CMD_INSERT) begin
            if (in_clock[31] || fill_adj == '0) begin
              state_next = csmt_pkg::S_EMIT;
            end else begin
              state_next = csmt_pkg::S_INS_SCAN;
            end
          end else if (items == '0) begin
            state_next = csmt_pkg::S_EMIT;
          end else begin
            state_next = csmt_pkg::S_RD_DATA;
          end
        end
      end
      csmt_pkg::S_INS_SCAN: begin
        if (!shift_on) begin
          state_next = csmt_pkg::S_EMIT;
        end else if (scan_dec == '0) begin
          state_next = csmt_pkg::S_INS_PUT;
        end
      end
      csmt_pkg::S_INS_PUT: begin
        state_next = csmt_pkg::S_EMIT;
      end
      csmt_pkg::S_RD_DATA: begin
        if (out_free && rd_idx == '0) begin
          state_next = csmt_pkg::S_IDLE;
        end
      end
      csmt_pkg::S_EMIT: begin
        if (out_free) begin
          state_next = csmt_pkg::S_IDLE;
        end
      end
      default: state_next = csmt_pkg::S_IDLE;
    endcase
  end

  // memory and output register control
  logic out_load;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = work_entry;
    mem_re    = 1'b0;
    mem_raddr = '0;
    out_load  = 1'b0;
    unique case (state)
      csmt_pkg::S_IDLE: begin
        if (accept) begin
          if (in_cmd == csmt_pkg::CMD_INSERT) begin
            if (!in_clock[31]) begin
              if (fill_adj == '0) begin
                mem_we    = 1'b1;
                mem_waddr = '0;
                mem_wdata = new_entry;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = fill_adj_dec[IDX_W-1:0];
              end
            end
          end else if (items != '0) begin
            mem_re    = 1'b1;
            mem_raddr = items_dec[IDX_W-1:0];
          end
        end
      end
      csmt_pkg::S_INS_SCAN: begin
        mem_we    = 1'b1;
        mem_waddr = scan_idx[IDX_W-1:0];
        if (shift_on) begin
          // move the older entry one slot toward the tail, fetch the next one
          mem_wdata = rdata;
          if (scan_dec != '0) begin
            mem_re    = 1'b1;
            mem_raddr = scan_dec2[IDX_W-1:0];
          end
        end else begin
          mem_wdata = work_entry;
        end
      end
      csmt_pkg::S_INS_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = scan_idx[IDX_W-1:0];
        mem_wdata = work_entry;
      end
      csmt_pkg::S_RD_DATA: begin
        if (out_free) begin
          out_load = 1'b1;
          if (rd_idx != '0) begin
            mem_re    = 1'b1;
            mem_raddr = rd_dec;
          end
        end
      end
      csmt_pkg::S_EMIT: begin
        out_load = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= csmt_pkg::S_IDLE;
      fill_count <= '0;
      capacity   <= csmt_pkg::CAP_W'(csmt_pkg::TABLE_DEPTH);
    end else begin
      state <= state_next;
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      if (state == csmt_pkg::S_IDLE && accept && in_cmd == csmt_pkg::CMD_INSERT) begin
        fill_count <= in_clock[31] ? fill_adj : (fill_adj + CNT_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      csmt_pkg::S_IDLE: begin
        if (accept) begin
          work_entry <= new_entry;
          scan_idx   <= fill_adj;
          rd_idx     <= items_dec[IDX_W-1:0];
          if (in_cmd == csmt_pkg::CMD_INSERT) begin
            res_evicted <= ins_evict;
            res_status  <= in_clock[31] ? csmt_pkg::STAT_REJECTED
                                        : csmt_pkg::STAT_INSERTED;
          end else begin
            res_evicted <= 1'b0;
            res_status  <= csmt_pkg::STAT_EMPTY;
          end
        end
      end
      csmt_pkg::S_INS_SCAN: begin
        if (shift_on) begin
          scan_idx <= scan_dec;
        end
      end
      csmt_pkg::S_RD_DATA: begin
        if (out_free && rd_idx != '0) begin
          rd_idx <= rd_dec;
        end
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata[csmt_pkg::OUT_DATA_W-1:69] <= '0;
      m_axis_tdata[68:64] <= fill_count;
      if (state == csmt_pkg::S_RD_DATA) begin
        m_axis_tuser       <= csmt_pkg::STAT_READ;
        m_axis_tdata[0]    <= 1'b0;
        m_axis_tdata[31:1] <= rdata.clock;
        m_axis_tdata[63:32] <= rdata.payload;
        m_axis_tlast       <= rd_idx == '0;
      end else begin
        m_axis_tuser       <= res_status;
        m_axis_tdata[0]    <= res_evicted;
        m_axis_tdata[31:1] <= '0;
        m_axis_tdata[63:32] <= '0;
        m_axis_tlast       <= 1'b1;
      end
    end
  end

  assign s_axis_tready = state == csmt_pkg::S_IDLE;

`include "clock_sorted_message_table_top_assert.svh"

  `CSMT_ASSERT_IMP(a_fill_range, clk, rst, 1'b1, 32'(fill_count) <= 32'(csmt_pkg::TABLE_DEPTH), "fill count above table depth")
  `CSMT_ASSERT_IMP(a_no_rw_clash, clk, rst, mem_we && mem_re, mem_waddr != mem_raddr, "read and write of one entry in one cycle")
  `CSMT_ASSERT_IMP(a_wr_insert_only, clk, rst, mem_we, state != csmt_pkg::S_RD_DATA && state != csmt_pkg::S_EMIT, "entry memory written outside an insert")
  `CSMT_ASSERT_NXT(a_load_valid, clk, rst, out_load, m_axis_tvalid, "loaded result not presented")
  `CSMT_ASSERT_IMP(a_no_load_busy, clk, rst, m_axis_tvalid && !m_axis_tready, !out_load, "result overwritten while stalled")

endmodule

`default_nettype wire
